@@ sv/pstq_pkg.sv @@
package pstq_pkg;

   // Number of slots in the list.
   localparam int CAPACITY = 16;
   // Width of a count that can hold CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Width of a slot index.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // Width of the occupancy field in a result.
   localparam int OCC_W = 5;

   // Operation codes carried in the kind field.
   typedef enum logic [2:0] {
      KIND_ADD      = 3'd0,
      KIND_REMOVE   = 3'd1,
      KIND_CONTAINS = 3'd2,
      KIND_FIRST    = 3'd3,
      KIND_NEXT     = 3'd4,
      KIND_CLEAR    = 3'd5
   } kind_type;

   // One request item.
   typedef struct packed {
      kind_type          kind;
      logic [7:0]        task_id;
      logic signed [7:0] priority_req;
   } req_type;

   // One result item.
   typedef struct packed {
      logic              success;
      logic [7:0]        entry_task;
      logic signed [7:0] entry_priority;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   // Contents of one slot of the list.
   typedef struct packed {
      logic              valid;
      logic [7:0]        task_id;
      logic signed [7:0] prio;
   } entry_type;

   // Command broadcast to every slot cell in the cycle of a transfer.
   typedef struct packed {
      logic              fire;
      kind_type          kind;
      logic [7:0]        task_id;
      logic signed [7:0] prio;
   } cmd_type;

   // Signals that ripple from one cell to the next one down the row.
   typedef struct packed {
      logic go;
      logic hit;
   } link_type;

endpackage

@@ sv/pstq_cell.sv @@
module pstq_cell import pstq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      add_ok,
   input  entry_type left_entry,
   input  entry_type right_entry,
   input  link_type  link_in,
   output link_type  link_out,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      go;
   logic      match;

   // A slot is a landing spot for a new task when it is empty or holds a
   // strictly lower priority; the flag stays set from there down the row.
   assign go    = !entry_ff.valid || (entry_ff.prio < cmd.prio);
   assign match = entry_ff.valid && (entry_ff.task_id == cmd.task_id);

   // The hit flag is set from the matching slot onward.
   assign link_out.go  = go;
   assign link_out.hit = link_in.hit || match;
   assign entry        = entry_ff;

   // Next slot contents: insert, shift toward the tail, close a gap, or clear.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.fire) begin
         case (cmd.kind)
            KIND_ADD: begin
               if (add_ok) begin
                  if (link_in.go) begin
                     entry_in = left_entry;
                  end else if (go) begin
                     entry_in.valid   = 1'b1;
                     entry_in.task_id = cmd.task_id;
                     entry_in.prio    = cmd.prio;
                  end
               end
            end
            KIND_REMOVE: begin
               if (link_out.hit) begin
                  entry_in = right_entry;
               end
            end
            KIND_CLEAR: begin
               entry_in.valid = 1'b0;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   // Reset leaves the slot empty with zeroed contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

@@ sv/priority_sorted_task_queue.sv @@
// Sorted task list kept in a row of slot cells, highest priority first.
// Requests arrive on req_valid / req_stall / req_data: add, remove,
// contains, first, next or clear. Each accepted request produces exactly one
// result on rsp_valid / rsp_stall / rsp_data, carrying the success flag, the
// entry under the walk cursor for first and next, and the occupancy after
// the operation. Every slot compares against the broadcast request and
// shifts to or from its neighbor in the same cycle, so one request is
// finished per clock: the result appears in the output register in the
// cycle after the transfer, and a new request is taken every cycle as long
// as the output register is free or being drained. The longest path is
// the ripple of the match flag down the row of CAPACITY cells.
// When the receiver holds rsp_stall with a result pending, req_stall is
// raised and the result holds steady until it is taken.
// Synchronous reset empties the list, zeroes the cursor and drops any
// pending result; requests are accepted in the first cycle after reset.
module priority_sorted_task_queue import pstq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   entry_type           cell_entry [CAPACITY];
   link_type            cell_link  [CAPACITY];
   cmd_type             cmd;
   logic                accept;
   logic                add_ok;
   logic                found;
   logic                full;
   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    fill_in;
   logic [CNT_W-1:0]    cursor_ff;
   logic [CNT_W-1:0]    cursor_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   entry_type           cursor_entry;

   // Handshake: take a request whenever the output register can take its result.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Broadcast command for the cells.
   assign cmd.fire    = accept;
   assign cmd.kind    = req_data.kind;
   assign cmd.task_id = req_data.task_id;
   assign cmd.prio    = req_data.priority_req;

   // The hit flag out of the last cell tells whether the id is present.
   assign found  = cell_link[CAPACITY-1].hit;
   assign full   = (fill_ff == CNT_W'(CAPACITY));
   assign add_ok = !full && !found;

   // Row of slot cells, each linked to its two neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      link_type  link_in;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign link_in    = '0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign link_in    = cell_link[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      pstq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .add_ok      (add_ok),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .link_in     (link_in),
         .link_out    (cell_link[i]),
         .entry       (cell_entry[i])
      );
   end

   // Fill count, cursor and the result of the current request.
   always_comb begin
      fill_in      = fill_ff;
      cursor_in    = cursor_ff;
      rsp_data_in  = '0;
      cursor_entry = '0;
      unique case (req_data.kind)
         KIND_ADD: begin
            if (add_ok) begin
               fill_in             = fill_ff + CNT_W'(1);
               rsp_data_in.success = 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (found) begin
               fill_in             = fill_ff - CNT_W'(1);
               rsp_data_in.success = 1'b1;
            end
         end
         KIND_CONTAINS: begin
            rsp_data_in.success = found;
         end
         KIND_FIRST: begin
            cursor_in = '0;
         end
         KIND_NEXT: begin
            if (cursor_ff < CNT_W'(CAPACITY)) begin
               cursor_in = cursor_ff + CNT_W'(1);
            end
         end
         KIND_CLEAR: begin
            fill_in   = '0;
            cursor_in = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase

      // Walk operations report the entry under the updated cursor.
      if ((req_data.kind == KIND_FIRST || req_data.kind == KIND_NEXT)
          && (cursor_in < fill_ff)) begin
         cursor_entry                = cell_entry[cursor_in[IDX_W-1:0]];
         rsp_data_in.success         = 1'b1;
         rsp_data_in.entry_task      = cursor_entry.task_id;
         rsp_data_in.entry_priority  = cursor_entry.prio;
      end
      rsp_data_in.occupancy = OCC_W'(fill_in);
   end

   // The output register holds its result until it is taken.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff   <= fill_in;
            cursor_ff <= cursor_in;
         end
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
